### hw/rtl/csvfs_pkg.sv
`default_nettype none

package csvfs_pkg;

    // Width of the running character position (saturating counter)
    localparam int POS_BITS = 16;
    // Width of the reported field length
    localparam int LEN_BITS = 16;
    localparam int CHAR_BITS = 8;
    localparam int CFG_IDX_BITS = 2;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_DELIMITER = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_QUOTE     = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_ESCAPE    = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_STRICT    = 2'd3;

    // Reset values of the configuration registers
    localparam logic [CHAR_BITS-1:0] RST_DELIMITER = 8'd44;
    localparam logic [CHAR_BITS-1:0] RST_QUOTE     = 8'd34;
    localparam logic [CHAR_BITS-1:0] RST_ESCAPE    = 8'd92;

    // End status codes
    localparam logic [1:0] ST_DELIM    = 2'd0;
    localparam logic [1:0] ST_END      = 2'd1;
    localparam logic [1:0] ST_STRAY    = 2'd2;
    localparam logic [1:0] ST_UNCLOSED = 2'd3;

    typedef struct packed {
        logic [CHAR_BITS-1:0] delimiter;
        logic [CHAR_BITS-1:0] quote;
        logic [CHAR_BITS-1:0] escape;
        logic                 strict;
    } t_cfg;

    // One classified character beat
    typedef struct packed {
        logic [CHAR_BITS-1:0] ch;
        logic                 is_final;
        logic                 is_delim;
        logic                 is_quote;
        logic                 is_escape;
        logic                 quote_is_escape;
    } t_beat;

    typedef struct packed {
        logic [LEN_BITS-1:0] field_length;
        logic [1:0]          end_status;
        logic                had_escape;
        logic                had_quotes;
    } t_result;

endpackage

`default_nettype wire

### hw/rtl/csvfs_front.sv
`default_nettype none

module csvfs_front (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [csvfs_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  wire logic [csvfs_pkg::CHAR_BITS-1:0]       i_cfg_data,
    input  wire logic [csvfs_pkg::CHAR_BITS-1:0]       i_char_in,
    input  wire logic                                  i_is_final,
    output csvfs_pkg::t_beat                           o_beat,
    output csvfs_pkg::t_cfg                            o_cfg
);
    import csvfs_pkg::*;

    t_cfg r_cfg;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delimiter <= RST_DELIMITER;
            r_cfg.quote     <= RST_QUOTE;
            r_cfg.escape    <= RST_ESCAPE;
            r_cfg.strict    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_DELIMITER: r_cfg.delimiter <= i_cfg_data;
                REG_QUOTE:     r_cfg.quote     <= i_cfg_data;
                REG_ESCAPE:    r_cfg.escape    <= i_cfg_data;
                REG_STRICT:    r_cfg.strict    <= i_cfg_data[0];
                default:       ;
            endcase
        end
    end

    // Character classification
    always_comb begin
        o_beat.ch              = i_char_in;
        o_beat.is_final        = i_is_final;
        o_beat.is_delim        = (i_char_in == r_cfg.delimiter);
        o_beat.is_quote        = (i_char_in == r_cfg.quote);
        o_beat.is_escape       = (i_char_in == r_cfg.escape);
        o_beat.quote_is_escape = (r_cfg.quote == r_cfg.escape);
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### hw/rtl/csvfs_queue.sv
`default_nettype none

module csvfs_queue (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire csvfs_pkg::t_beat i_beat,
    output logic            o_full,
    input  wire logic       i_pop,
    output logic            o_empty,
    output csvfs_pkg::t_beat o_beat
);
    import csvfs_pkg::*;

    t_beat                r_entry [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QCNT_BITS-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == QCNT_BITS'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_beat  = r_entry[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_beat;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                      : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                      : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/csvfs_back.sv
`default_nettype none

module csvfs_back (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire csvfs_pkg::t_cfg  i_cfg,
    input  wire logic        i_beat_valid,
    input  wire csvfs_pkg::t_beat i_beat,
    output logic             o_beat_pop,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output csvfs_pkg::t_result o_result
);
    import csvfs_pkg::*;

    localparam int WIDE_BITS = (POS_BITS > LEN_BITS) ? POS_BITS : LEN_BITS;
    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    // Field state
    logic                 r_quote_open;
    logic                 r_close_pending;
    logic [POS_BITS-1:0]  r_esc_pos;
    logic                 r_escape_seen;
    logic                 r_quotes_seen;
    logic [POS_BITS-1:0]  r_char_pos;
    logic [CHAR_BITS-1:0] r_prev_char;

    logic    r_out_valid;
    t_result r_result;

    logic                 n_quote_open;
    logic                 n_close_pending;
    logic [POS_BITS-1:0]  n_esc_pos;
    logic                 n_escape_seen;
    logic                 n_quotes_seen;
    logic                 n_emit;
    logic [1:0]           n_status;
    logic [POS_BITS-1:0]  n_len;
    logic [POS_BITS-1:0]  len_inc;
    logic [POS_BITS:0]    esc_next;
    logic [WIDE_BITS-1:0] len_wide;
    logic                 take;

    // A beat is taken whenever the output register is free or being drained
    assign take       = i_beat_valid && (!r_out_valid || i_out_ready);
    assign o_beat_pop = take;

    assign len_inc = (r_char_pos < POS_MAX) ? r_char_pos + 1'b1 : POS_MAX;

    // Per-character update
    always_comb begin
        n_quote_open    = r_quote_open;
        n_close_pending = r_close_pending;
        n_esc_pos       = r_esc_pos;
        n_escape_seen   = r_escape_seen;
        n_quotes_seen   = r_quotes_seen;
        n_emit          = 1'b0;
        n_status        = ST_END;
        n_len           = len_inc;
        esc_next        = '0;

        // settle a pending close with this lookahead character
        if (n_close_pending) begin
            n_close_pending = 1'b0;
            n_quote_open    = !i_beat.is_delim;
        end

        if (i_beat.is_delim && !n_quote_open) begin
            n_emit   = 1'b1;
            n_status = ST_DELIM;
            n_len    = r_char_pos;
        end else begin
            if (n_quote_open && !i_beat.quote_is_escape && i_beat.is_escape) begin
                n_esc_pos = r_char_pos;
            end

            if (i_beat.is_quote) begin
                if (!n_quote_open) begin
                    n_quote_open = 1'b1;
                    if (i_cfg.strict && (r_char_pos > POS_BITS'(1))
                            && (r_prev_char != i_cfg.delimiter)) begin
                        n_emit   = 1'b1;
                        n_status = ST_STRAY;
                    end else if (i_beat.quote_is_escape) begin
                        n_esc_pos = r_char_pos;
                    end
                end else begin
                    esc_next = {1'b0, n_esc_pos} + 1'b1;
                    if (esc_next == {1'b0, r_char_pos}) begin
                        n_escape_seen = 1'b1;
                    end else begin
                        n_esc_pos       = r_char_pos;
                        n_close_pending = 1'b1;
                    end
                    n_quotes_seen = 1'b1;
                end
            end

            // end of input: lookahead past the end closes a pending quote
            if (!n_emit && i_beat.is_final) begin
                n_emit = 1'b1;
                if (n_close_pending) begin
                    n_close_pending = 1'b0;
                    n_quote_open    = 1'b0;
                end
                n_status = (n_quote_open && !i_beat.is_quote) ? ST_UNCLOSED : ST_END;
            end
        end
    end

    assign len_wide = WIDE_BITS'(n_len);

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quote_open    <= 1'b0;
            r_close_pending <= 1'b0;
            r_esc_pos       <= '0;
            r_escape_seen   <= 1'b0;
            r_quotes_seen   <= 1'b0;
            r_char_pos      <= '0;
            r_prev_char     <= '0;
        end else if (take) begin
            if (n_emit) begin
                r_quote_open    <= 1'b0;
                r_close_pending <= 1'b0;
                r_esc_pos       <= '0;
                r_escape_seen   <= 1'b0;
                r_quotes_seen   <= 1'b0;
                r_char_pos      <= '0;
                r_prev_char     <= '0;
            end else begin
                r_quote_open    <= n_quote_open;
                r_close_pending <= n_close_pending;
                r_esc_pos       <= n_esc_pos;
                r_escape_seen   <= n_escape_seen;
                r_quotes_seen   <= n_quotes_seen;
                r_char_pos      <= len_inc;
                r_prev_char     <= i_beat.ch;
            end
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= n_emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (take && n_emit) begin
            r_result.field_length <= (len_wide > WIDE_BITS'({LEN_BITS{1'b1}}))
                                     ? {LEN_BITS{1'b1}} : len_wide[LEN_BITS-1:0];
            r_result.end_status   <= n_status;
            r_result.had_escape   <= n_escape_seen;
            r_result.had_quotes   <= n_quotes_seen;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    // a pending close only exists inside an open quoted section
    a_pending_in_quote: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_close_pending |-> r_quote_open)
        else $error("close pending without open quote");

    // the escape mark never runs ahead of the position
    a_esc_behind_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_esc_pos <= r_char_pos)
        else $error("escape position beyond character position");

    // a fresh field carries no quote state
    a_fresh_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_char_pos == '0) |-> (!r_quote_open && !r_quotes_seen && !r_escape_seen))
        else $error("quote state left over in a new field");

    // a stalled result is not overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !take)
        else $error("beat taken while result stalled");

endmodule

`default_nettype wire

### hw/rtl/csv_field_scanner.sv
// Channel | Direction | Handshake                 | Beat
// --------+-----------+---------------------------+-----------------------------------
// in      | input     | i_in_valid / o_in_ready   | i_char_in, i_is_final
// out     | output    | o_out_valid / i_out_ready | o_field_length, o_end_status,
//         |           |                           | o_had_escape, o_had_quotes
// cfg     | input     | i_cfg_we (no ready)       | i_cfg_index, i_cfg_data
//
// One character per cycle sustained while results are drained; a character is first
// registered in the queue, then taken into the state update, and a result is loaded
// into the output register when its last character is taken.
// The per-character state update in the back part is a loop through its state registers.
// While a result waits on i_out_ready the back part stalls; the two-entry queue
// fills and then o_in_ready drops.
// Synchronous active-low reset restores the register defaults and starts a new field.
`default_nettype none

module csv_field_scanner (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [csvfs_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [csvfs_pkg::CHAR_BITS-1:0]    i_cfg_data,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [csvfs_pkg::CHAR_BITS-1:0]    i_char_in,
    input  wire logic                               i_is_final,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [csvfs_pkg::LEN_BITS-1:0]          o_field_length,
    output logic [1:0]                              o_end_status,
    output logic                                    o_had_escape,
    output logic                                    o_had_quotes
);
    import csvfs_pkg::*;

    t_beat   front_beat;
    t_beat   queue_beat;
    t_cfg    cfg;
    t_result result;
    logic    queue_full;
    logic    queue_empty;
    logic    beat_pop;

    assign o_in_ready = !queue_full;

    csvfs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_char_in   (i_char_in),
        .i_is_final  (i_is_final),
        .o_beat      (front_beat),
        .o_cfg       (cfg)
    );

    csvfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_beat  (front_beat),
        .o_full  (queue_full),
        .i_pop   (beat_pop),
        .o_empty (queue_empty),
        .o_beat  (queue_beat)
    );

    csvfs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_beat_valid (!queue_empty),
        .i_beat       (queue_beat),
        .o_beat_pop   (beat_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_result     (result)
    );

    assign o_field_length = result.field_length;
    assign o_end_status   = result.end_status;
    assign o_had_escape   = result.had_escape;
    assign o_had_quotes   = result.had_quotes;

endmodule

`default_nettype wire
